// ===== rtl/agsb_pkg.sv =====
package agsb_pkg;

  // Width of the saturated batch limit compare (holds BATCH_MAX up to 64)
  localparam int LIM_W = 7;
  // Width of the saturated defer capacity compare (holds DEFER_DEPTH up to 65536)
  localparam int CAP_W = 17;

  // Default sizes
  localparam int BATCH_MAX_DEF    = 32;
  localparam int DEFER_DEPTH_DEF  = 256;
  localparam int SESSION_BITS_DEF = 64;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int SESSION_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Event codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_NEW    = 2'd0,
    ACT_ACK    = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_IMMEDIATELY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_DEADLINE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFER_CAPACITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT       = 3'd4;

  // Configuration reset values
  localparam logic [15:0] DEADLINE_RST = 16'd2000;
  localparam logic [8:0]  CAPACITY_RST = 9'd256;
  localparam logic [5:0]  LIMIT_RST    = 6'd32;

endpackage

// ===== rtl/ack_gated_session_batcher_top.sv =====
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------------
// request   | start, action, session_data, busy         | taken when start & !busy
// result    | batch_strobe, batch_session, batch_last   | one cycle per strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when cfg_valid & cfg_ready
//
// A request drains deferred records into the batch one at a time (S_DRAIN, S_DRAIN_WR),
// then places the session and decides (S_PLACE, S_DECIDE); a flush emits the batch.
// The batch memory and the deferred FIFO memory each have one write and one read port,
// and every drained record passes through both, so S_DRAIN_WR writes what the FIFO read.
// A request ignored (sync disabled or unused action) leaves busy low.
// Reset is synchronous and active high; no clearing pass is needed. Results cannot be stalled.
module ack_gated_session_batcher_top #(
  parameter int BATCH_MAX    = agsb_pkg::BATCH_MAX_DEF,
  parameter int DEFER_DEPTH  = agsb_pkg::DEFER_DEPTH_DEF,
  parameter int SESSION_BITS = agsb_pkg::SESSION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [agsb_pkg::ACTION_W-1:0]  action,
  input  logic [agsb_pkg::SESSION_W-1:0] session_data,
  output logic                           batch_strobe,
  output logic [agsb_pkg::SESSION_W-1:0] batch_session,
  output logic                           batch_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [agsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agsb_pkg::CFG_DAT_W-1:0] cfg_data
);
  import agsb_pkg::*;

  localparam int CNT_W  = $clog2(BATCH_MAX + 1);
  localparam int BIDX_W = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
  localparam int DIDX_W = $clog2(DEFER_DEPTH);
  localparam int DCNT_W = $clog2(DEFER_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DRAIN, S_DRAIN_WR, S_PLACE, S_DECIDE, S_EMIT, S_FINISH
  } state_t;

  // Configuration
  logic        sync_enabled;
  logic        flush_immediately;
  logic [15:0] flush_deadline_ticks;
  logic [8:0]  defer_capacity;
  logic [5:0]  batch_limit;

  // Sequencer state
  state_t                    state;
  action_t                   act;
  logic [SESSION_BITS-1:0]   rec;
  logic [CNT_W-1:0]          batch_count;
  logic                      batch_full_mark;
  logic [DIDX_W-1:0]         defer_head;
  logic [DIDX_W-1:0]         defer_tail;
  logic [DCNT_W-1:0]         defer_count;
  logic                      ack_pending;
  logic [31:0]               now_ticks;
  logic [31:0]               last_flush_ticks;
  logic [CNT_W-1:0]          emit_idx;
  logic                      emit_last;

  // Memories
  logic [SESSION_BITS-1:0] batch_store [BATCH_MAX];
  logic [SESSION_BITS-1:0] defer_fifo  [DEFER_DEPTH];
  logic [SESSION_BITS-1:0] bs_rdata;
  logic [SESSION_BITS-1:0] df_rdata;
  logic                    bs_we;
  logic [SESSION_BITS-1:0] bs_wdata;
  logic                    df_we;

  // Compare logic and derived values
  logic              accept;
  logic              item_live;
  logic [LIM_W-1:0]  lim_eff;
  logic [CAP_W-1:0]  cap_eff;
  logic              batch_room;
  logic              defer_room;
  logic [31:0]       due;
  logic              flush_go;
  logic [DIDX_W-1:0] head_next;
  logic [DIDX_W-1:0] tail_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign item_live = sync_enabled && (action_t'(action) != ACT_UNUSED);

  // Saturate limits to the physical sizes
  assign lim_eff = (LIM_W'(batch_limit) > LIM_W'(BATCH_MAX)) ?
                   LIM_W'(BATCH_MAX) : LIM_W'(batch_limit);
  assign cap_eff = (CAP_W'(defer_capacity) > CAP_W'(DEFER_DEPTH)) ?
                   CAP_W'(DEFER_DEPTH) : CAP_W'(defer_capacity);

  assign batch_room = LIM_W'(batch_count) < lim_eff;
  assign defer_room = CAP_W'(defer_count) < cap_eff;

  assign head_next = (CAP_W'(defer_head) + 1'b1 >= CAP_W'(DEFER_DEPTH)) ?
                     '0 : defer_head + 1'b1;
  assign tail_next = (CAP_W'(defer_tail) + 1'b1 >= CAP_W'(DEFER_DEPTH)) ?
                     '0 : defer_tail + 1'b1;

  // Wrap-safe deadline check
  assign due      = last_flush_ticks + 32'(flush_deadline_ticks) - now_ticks;
  assign flush_go = (batch_count != '0) &&
                    (due[31] || (ack_pending && (flush_immediately || batch_full_mark)));

  // Steer the single batch write port and the deferred FIFO write enable
  always_comb begin
    bs_we    = 1'b0;
    bs_wdata = rec;
    df_we    = 1'b0;
    unique case (state)
      S_DRAIN_WR: begin
        bs_we    = 1'b1;
        bs_wdata = df_rdata;
      end
      S_PLACE: begin
        if (act == ACT_NEW) begin
          bs_we = batch_room;
          df_we = !batch_room && defer_room;
        end
      end
      default: begin
        bs_we = 1'b0;
      end
    endcase
  end

  // Batch memory
  always_ff @(posedge clk) begin
    if (bs_we) begin
      batch_store[batch_count[BIDX_W-1:0]] <= bs_wdata;
    end
    bs_rdata <= batch_store[emit_idx[BIDX_W-1:0]];
  end

  // Deferred FIFO memory
  always_ff @(posedge clk) begin
    if (df_we) begin
      defer_fifo[defer_tail] <= rec;
    end
    df_rdata <= defer_fifo[defer_head];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_enabled         <= 1'b0;
      flush_immediately    <= 1'b0;
      flush_deadline_ticks <= DEADLINE_RST;
      defer_capacity       <= CAPACITY_RST;
      batch_limit          <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_ENABLED:      sync_enabled         <= cfg_data[0];
        REG_FLUSH_IMMEDIATELY: flush_immediately    <= cfg_data[0];
        REG_FLUSH_DEADLINE:    flush_deadline_ticks <= cfg_data;
        REG_DEFER_CAPACITY:    defer_capacity       <= cfg_data[8:0];
        REG_BATCH_LIMIT:       batch_limit          <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      act              <= ACT_NEW;
      batch_count      <= '0;
      batch_full_mark  <= 1'b0;
      defer_head       <= '0;
      defer_tail       <= '0;
      defer_count      <= '0;
      ack_pending      <= 1'b1;
      now_ticks        <= '0;
      last_flush_ticks <= '0;
      emit_idx         <= '0;
      emit_last        <= 1'b0;
      batch_strobe     <= 1'b0;
    end else begin
      // Strobe each record read out of the batch on the following cycle
      batch_strobe <= (state == S_EMIT);
      unique case (state)
        S_IDLE: begin
          if (accept && item_live) begin
            act   <= action_t'(action);
            rec   <= session_data[SESSION_BITS-1:0];
            state <= S_DRAIN;
            if (action_t'(action) == ACT_ACK) begin
              ack_pending <= 1'b1;
            end
            if (action_t'(action) == ACT_TICK) begin
              now_ticks <= now_ticks + 32'd1;
            end
          end
        end
        S_DRAIN: begin
          // Move deferred records while the batch has room
          if (defer_count == '0) begin
            state <= S_PLACE;
          end else if (!batch_room) begin
            batch_full_mark <= 1'b1;
            state           <= S_PLACE;
          end else begin
            state <= S_DRAIN_WR;
          end
        end
        S_DRAIN_WR: begin
          batch_count <= batch_count + 1'b1;
          defer_head  <= head_next;
          defer_count <= defer_count - 1'b1;
          state       <= S_DRAIN;
        end
        S_PLACE: begin
          // Batch the new session, else defer or drop it
          if (act == ACT_NEW) begin
            if (batch_room) begin
              batch_count <= batch_count + 1'b1;
            end else begin
              batch_full_mark <= 1'b1;
              if (defer_room) begin
                defer_tail  <= tail_next;
                defer_count <= defer_count + 1'b1;
              end
            end
          end
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (flush_go) begin
            batch_full_mark  <= 1'b0;
            ack_pending      <= 1'b0;
            last_flush_ticks <= now_ticks;
            emit_idx         <= '0;
            state            <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          // Read one record a cycle; it leaves on the next cycle
          emit_last <= (emit_idx == batch_count - 1'b1);
          if (emit_idx == batch_count - 1'b1) begin
            state <= S_FINISH;
          end else begin
            emit_idx <= emit_idx + 1'b1;
          end
        end
        S_FINISH: begin
          batch_count <= '0;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign batch_session = SESSION_W'(bs_rdata);
  assign batch_last    = emit_last;

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    batch_strobe |-> busy)
    else $error("result strobe outside a request");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (batch_strobe && batch_last) |=> !batch_strobe)
    else $error("result after the final record of a batch");

  a_defer_bound: assert property (@(posedge clk) disable iff (rst)
    CAP_W'(defer_count) <= CAP_W'(DEFER_DEPTH))
    else $error("deferred count beyond FIFO depth");

  a_batch_bound: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(batch_count) <= LIM_W'(BATCH_MAX))
    else $error("batch count beyond batch memory");

  a_ignored: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !sync_enabled) |=> !busy)
    else $error("request taken while sync disabled");
`endif

endmodule
